// ===== design/mce_pkg.sv =====
package mce_pkg;

  localparam int CHAR_W      = 8;
  localparam int SYM_W       = 2;
  localparam int ELEM_MAX    = 6;
  localparam int CODE_W      = ELEM_MAX + 1;
  localparam int LEN_W       = $clog2(ELEM_MAX + 1);
  localparam int ELEM_IDX_W  = $clog2(ELEM_MAX);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SYM_W-1:0] SYM_DOT  = 2'd0;
  localparam logic [SYM_W-1:0] SYM_DASH = 2'd1;
  localparam logic [SYM_W-1:0] SYM_SEP  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_EXCL   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

  // Marker-bit form: highest set bit marks the start, elements below it, 1 = dash.
  localparam logic [CODE_W-1:0] LETTER_CODE [26] = '{
    7'd5, 7'd24, 7'd26, 7'd12, 7'd2, 7'd18, 7'd14, 7'd16, 7'd4, 7'd23, 7'd13, 7'd20, 7'd7,
    7'd6, 7'd15, 7'd22, 7'd29, 7'd10, 7'd8, 7'd3, 7'd9, 7'd17, 7'd11, 7'd25, 7'd27, 7'd28
  };

  localparam logic [CODE_W-1:0] DIGIT_CODE [10] = '{
    7'd63, 7'd47, 7'd39, 7'd35, 7'd33, 7'd32, 7'd48, 7'd56, 7'd60, 7'd62
  };

  localparam logic [CODE_W-1:0] CODE_PERIOD = 7'd85;
  localparam logic [CODE_W-1:0] CODE_COMMA  = 7'd115;
  localparam logic [CODE_W-1:0] CODE_EXCL   = 7'd57;
  localparam logic [CODE_W-1:0] CODE_QUEST  = 7'd76;
  // Marker only: no elements, separator alone.
  localparam logic [CODE_W-1:0] CODE_SPACE  = 7'd1;
  localparam logic [CODE_W-1:0] CODE_NONE   = 7'd0;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [ELEM_MAX-1:0] elems;   // left-aligned, first element at the top
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CODE_W-1:0] code_lookup(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [CHAR_W-1:0] ofs;
    logic [CODE_W-1:0] code;
    u = c;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      u = c - CASE_OFS;
    end
    code = CODE_NONE;
    if (u >= CH_UP_A && u <= CH_UP_Z) begin
      ofs  = u - CH_UP_A;
      code = LETTER_CODE[ofs[4:0]];
    end else if (u >= CH_ZERO && u <= CH_NINE) begin
      ofs  = u - CH_ZERO;
      code = DIGIT_CODE[ofs[3:0]];
    end else begin
      case (u)
        CH_PERIOD: code = CODE_PERIOD;
        CH_COMMA:  code = CODE_COMMA;
        CH_EXCL:   code = CODE_EXCL;
        CH_QUEST:  code = CODE_QUEST;
        CH_SPACE:  code = CODE_SPACE;
        default:   code = CODE_NONE;
      endcase
    end
    return code;
  endfunction

endpackage

// ===== design/mce_front.sv =====
module mce_front
  import mce_pkg::*;
(
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              in_stall,
  input  q_status_t         q_status,
  output logic              push,
  output job_t              push_job
);

  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  len;
  logic [CODE_W-1:0] aligned;

  always_comb begin
    code = code_lookup(in_char_code);
    len  = '0;
    for (int i = 1; i < CODE_W; i++) begin
      if (code[i]) begin
        len = LEN_W'(i);
      end
    end
    // Move the marker to the top so the first element lands in the MSB.
    aligned        = CODE_W'(code << (LEN_W'(ELEM_MAX) - len));
    push_job.len   = len;
    push_job.elems = aligned[ELEM_MAX-1:0];
  end

  assign in_stall = q_status.full;
  // Drop characters without a code.
  assign push     = in_valid && !q_status.full && (code != CODE_NONE);

endmodule

// ===== design/mce_queue.sv =====
module mce_queue
  import mce_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head           = mem_r[rd_ptr_r];
  assign q_status.full  = (count_r == CNT_W'(DEPTH));
  assign q_status.empty = (count_r == '0);

endmodule

// ===== design/mce_back.sv =====
module mce_back
  import mce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  job_t             head,
  input  q_status_t        q_status,
  output logic             pop,
  output logic             out_valid,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_last,
  input  logic             out_stall
);

  logic                  out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]      out_symbol_r, out_symbol_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [LEN_W-1:0]      pos_r, pos_nxt;
  logic                  slot_free;
  logic [ELEM_IDX_W-1:0] sel;

  assign slot_free = !out_valid_r || !out_stall;
  assign sel       = ELEM_IDX_W'(ELEM_MAX - 1) - pos_r[ELEM_IDX_W-1:0];

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    pos_nxt        = pos_r;
    pop            = 1'b0;
    if (slot_free) begin
      out_valid_nxt = !q_status.empty;
      if (!q_status.empty) begin
        if (pos_r < head.len) begin
          out_symbol_nxt = head.elems[sel] ? SYM_DASH : SYM_DOT;
          out_last_nxt   = 1'b0;
          pos_nxt        = pos_r + 1'b1;
        end else begin
          // Close the run and retire the entry.
          out_symbol_nxt = SYM_SEP;
          out_last_nxt   = 1'b1;
          pos_nxt        = '0;
          pop            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

// ===== design/morse_code_encoder.sv =====
// A taken character beat is written into the queue register, and its first symbol beat
// is then registered in the output register. Throughput: one symbol beat per cycle while
// out_stall is low; a character sends its elements (one to six) and then a separator
// (the separator alone for a space). Characters without a code are taken but send nothing.
// Reset: synchronous, active low; empties the queue and the output register.
module morse_code_encoder
  import mce_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              in_stall,
  output logic              out_valid,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_last,
  input  logic              out_stall
);

  // Front decodes each character into an element count and left-aligned
  // dot/dash bits; the queue decouples it from the symbol sequencer.
  q_status_t q_status;
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      head;

  mce_front u_front (
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .q_status     (q_status),
    .push         (push),
    .push_job     (push_job)
  );

  mce_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back walks the head entry one element per beat, then sends the
  // separator marked last and advances the queue on that same beat.
  mce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_stall  (out_stall)
  );

endmodule

// ===== sim/morse_code_encoder_tb.sv =====
module morse_code_encoder_tb;
  import mce_pkg::*;

  // One symbol beat as the result channel carries it.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } symbol_beat_t;

  // Track the symbol beats still owed by the block, in sending order.
  class morse_scoreboard;
    symbol_beat_t owed_symbols[$];
    int chars_taken = 0;
    int coded_chars = 0;
    int checked     = 0;
    int errors      = 0;

    // Give the dot/dash pattern of a character, empty when it has no code.
    // Written in plain Morse notation so it stays independent of the
    // marker-bit tables inside the block.
    function string pattern_of(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      u = c;
      if (u >= "a" && u <= "z") begin
        u = u - 8'd32;
      end
      case (u)
        "A": return ".-";
        "B": return "-...";
        "C": return "-.-.";
        "D": return "-..";
        "E": return ".";
        "F": return "..-.";
        "G": return "--.";
        "H": return "....";
        "I": return "..";
        "J": return ".---";
        "K": return "-.-";
        "L": return ".-..";
        "M": return "--";
        "N": return "-.";
        "O": return "---";
        "P": return ".--.";
        "Q": return "--.-";
        "R": return ".-.";
        "S": return "...";
        "T": return "-";
        "U": return "..-";
        "V": return "...-";
        "W": return ".--";
        "X": return "-..-";
        "Y": return "-.--";
        "Z": return "--..";
        "0": return "-----";
        "1": return ".----";
        "2": return "..---";
        "3": return "...--";
        "4": return "....-";
        "5": return ".....";
        "6": return "-....";
        "7": return "--...";
        "8": return "---..";
        "9": return "----.";
        ".": return ".-.-.-";
        ",": return "--..--";
        "!": return "--..-";   // kept as the block defines it, not the standard code
        "?": return "..--..";
        default: return "";
      endcase
    endfunction

    // Note an accepted character beat and queue the symbols it must produce.
    function void note_char(logic [CHAR_W-1:0] c);
      string        pat;
      symbol_beat_t b;
      chars_taken++;
      if (c == CH_SPACE) begin
        coded_chars++;
        b.symbol = SYM_SEP;
        b.last   = 1'b1;
        owed_symbols.push_back(b);
        return;
      end
      pat = pattern_of(c);
      if (pat.len() == 0) begin
        return;
      end
      coded_chars++;
      for (int i = 0; i < pat.len(); i++) begin
        b.symbol = (pat[i] == "-") ? SYM_DASH : SYM_DOT;
        b.last   = 1'b0;
        owed_symbols.push_back(b);
      end
      b.symbol = SYM_SEP;
      b.last   = 1'b1;
      owed_symbols.push_back(b);
    endfunction

    // Compare one accepted symbol beat with the oldest one owed.
    function void check_symbol(logic [SYM_W-1:0] sym, logic lst);
      symbol_beat_t want;
      if (owed_symbols.size() == 0) begin
        $display("%0t: symbol beat with none owed: expected nothing, actual symbol=%0d last=%0b",
                 $time, sym, lst);
        errors++;
        return;
      end
      want = owed_symbols.pop_front();
      checked++;
      if (sym !== want.symbol) begin
        $display("%0t: symbol mismatch: expected %0d, actual %0d", $time, want.symbol, sym);
        errors++;
      end
      if (lst !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return owed_symbols.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic [CHAR_W-1:0] in_char_code;
  logic              in_stall;
  logic              out_valid;
  logic [SYM_W-1:0]  out_symbol;
  logic              out_last;
  logic              out_stall;

  // Per-cycle idle odds in percent, and a long receiver hold-off counter.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_cycles  = 0;

  morse_scoreboard sb = new();

  morse_code_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_char_code(in_char_code),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_symbol  (out_symbol),
    .out_last    (out_last),
    .out_stall   (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout: %0d symbol beats still owed", sb.pending());
    $display("FAIL");
    $finish;
  end

  // Drive the receiver's stall. A requested hold-off wins over the random
  // stall; count it down here on every edge.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Check every symbol beat the receiver takes. Values read here are the
  // ones that stood before the edge, since all drives are nonblocking.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_symbol(out_symbol, out_last);
    end
  end

  // Offer one character beat, hold it until taken, then idle at random.
  // Leave valid high when no idle follows so back-to-back beats never see
  // a drop and raise in the same step.
  task automatic send_char(input logic [CHAR_W-1:0] c);
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(c);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid     <= 1'b0;
      in_char_code <= CHAR_W'($urandom_range(0, 255));
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed symbol has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly characters with a code, with a tail of arbitrary bytes.
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    if (r < 25) return CH_UP_A + CHAR_W'($urandom_range(0, 25));
    if (r < 45) return CH_LO_A + CHAR_W'($urandom_range(0, 25));
    if (r < 60) return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    if (r < 72) begin
      case (k)
        0:       return CH_PERIOD;
        1:       return CH_COMMA;
        2:       return CH_EXCL;
        default: return CH_QUEST;
      endcase
    end
    if (r < 80) return CH_SPACE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Send random characters until n more of them carried a code.
  task automatic send_random(input int n);
    int target;
    target = sb.coded_chars + n;
    while (sb.coded_chars < target) begin
      send_char(pick_char());
    end
  endtask

  logic [CHAR_W-1:0] directed_chars [22];

  initial begin
    directed_chars = '{
      8'h00, 8'hFF, CH_UP_A, CH_UP_Z, CH_LO_A, CH_LO_Z, CH_ZERO, CH_NINE,
      CH_PERIOD, CH_COMMA, CH_EXCL, CH_QUEST, CH_SPACE, "E", "T", "5",
      8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h80
    };
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_code <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles lightly, receiver stalls often.
    tx_idle_pct  = 10;
    rx_stall_pct = 56;
    foreach (directed_chars[i]) begin
      send_char(directed_chars[i]);
    end
    send_random(24);

    // Hold the receiver off for a long stretch while the sender keeps
    // offering beats back to back, so the block fills and stalls its input.
    wait_drained();
    tx_idle_pct = 0;
    hold_cycles = 80;
    send_random(10);
    // Pause the sender until the backlog has fully drained.
    wait_drained();

    // Swap the idle mix.
    tx_idle_pct  = 56;
    rx_stall_pct = 10;
    send_random(20);
    wait_drained();

    // Full rate on both sides.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_random(20);

    // Drain, then watch a little longer for stray beats.
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d character beats (%0d without a code) and %0d symbol beats checked,",
             sb.chars_taken, sb.chars_taken - sb.coded_chars, sb.checked);
    $display("under three idle mixes, a long receiver hold-off and a full drain; %0d errors.",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
